>>> rtl/vlnts_pkg.sv
// Package for the volume-locked noise template subtraction block.
// Holds sizes, register indexes and the structs shared by the modules.
// No dependencies.
`default_nettype none

package vlnts_pkg;

  localparam int unsigned MaxTemplate = 65536;
  localparam int unsigned AddrW       = $clog2(MaxTemplate);
  localparam int unsigned IdxW        = AddrW + 1;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned SliceW      = 8;
  localparam int unsigned CfgDataW    = 17;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CfgSlicesPerVolume = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockLength     = 1'b1;

  localparam logic [SampleW-1:0] MidScale = 16'h8000;

  typedef struct packed {
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic [SampleW-1:0] wdata;
    logic               re;
    logic [AddrW-1:0]   raddr;
  } tmem_req_t;

  typedef struct packed {
    logic produce;
    logic beyond;
    logic bypass;
  } item_info_t;

endpackage

`default_nettype wire

>>> rtl/vlnts_ctrl.sv
// Slice and volume counting plus template write and read pointers.
// Issues template write and read requests only for accepted samples while capturing. Depends on vlnts_pkg.
`default_nettype none

module vlnts_ctrl import vlnts_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               mode_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic [SliceW-1:0]  slices_per_volume_i,
  input  wire logic [IdxW-1:0]    block_length_i,
  output tmem_req_t               req_o,
  output item_info_t              info_o
);

  logic [SliceW-1:0] slice_q, slice_d;
  logic [1:0]        vol_q, vol_d;
  logic [IdxW-1:0]   cap_q, cap_d;
  logic [IdxW-1:0]   rd_q, rd_d;
  logic [IdxW-1:0]   eff_len;
  logic [SliceW-1:0] slice_inc;
  logic              capturing;
  logic              can_write;
  logic              can_read;

  assign eff_len = (block_length_i > IdxW'(MaxTemplate)) ? IdxW'(MaxTemplate)
                                                         : block_length_i;
  assign capturing = (vol_q == 2'd2);
  assign can_write = capturing && (cap_q < eff_len);
  assign can_read  = rd_q < eff_len;
  assign slice_inc = slice_q + SliceW'(1);

  always_comb begin
    slice_d = slice_q;
    vol_d   = vol_q;
    cap_d   = cap_q;
    rd_d    = rd_q;
    if (accept_i && mode_i) begin
      if (slice_q == '0) begin
        rd_d = '0;
        if (vol_q < 2'd2) begin
          vol_d = vol_q + 2'd1;
          if (vol_q == 2'd1) begin
            cap_d = '0;
          end
        end
      end
      slice_d = (slice_inc >= slices_per_volume_i) ? '0 : slice_inc;
    end else if (accept_i && capturing) begin
      if (can_write) begin
        cap_d = cap_q + IdxW'(1);
      end
      if (can_read) begin
        rd_d = rd_q + IdxW'(1);
      end
    end
  end

  always_comb begin
    req_o.we     = accept_i && !mode_i && can_write;
    req_o.waddr  = cap_q[AddrW-1:0];
    req_o.wdata  = sample_i;
    req_o.re     = accept_i && !mode_i && capturing && can_read;
    req_o.raddr  = rd_q[AddrW-1:0];
    info_o.produce = !mode_i && capturing;
    info_o.beyond  = !can_read;
    info_o.bypass  = can_write && (cap_q == rd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= '0;
      vol_q   <= '0;
      cap_q   <= '0;
      rd_q    <= '0;
    end else begin
      slice_q <= slice_d;
      vol_q   <= vol_d;
      cap_q   <= cap_d;
      rd_q    <= rd_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vlnts_tmem.sv
// Template store: one write port and one registered read port.
// Contents are undefined until written. Depends on vlnts_pkg.
`default_nettype none

module vlnts_tmem import vlnts_pkg::*; (
  input  wire logic         clk_i,
  input  wire tmem_req_t    req_i,
  output logic [SampleW-1:0] rdata_o
);

  logic [SampleW-1:0] mem [MaxTemplate];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/volume_locked_noise_template_subtract.sv
// Volume-locked noise template subtraction, top level.
// A sample's result passes through the read stage and then the output register.
// Throughput: one item per cycle while the output is not stalled.
// Reset clears the counters, pointers and valid flags and sets the configuration to its defaults.
// The template memory is not cleared and needs no clearing pass.
// Depends on vlnts_pkg, vlnts_ctrl and vlnts_tmem.
`default_nettype none

module volume_locked_noise_template_subtract import vlnts_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                mode_i,
  input  wire logic [SampleW-1:0]  sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SampleW-1:0]       filtered_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [SliceW-1:0]  spv_q;
  logic [IdxW-1:0]    blen_q;
  logic               accept;
  logic               out_ready;
  logic               s1_move;
  tmem_req_t          req;
  item_info_t         info;
  logic [SampleW-1:0] rdata;

  logic               s1_valid_q;
  logic               s1_beyond_q;
  logic               s1_bypass_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               out_valid_q;
  logic [SampleW-1:0] filtered_q, filtered_d;
  logic [SampleW-1:0] tmpl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spv_q  <= SliceW'(1);
      blen_q <= IdxW'(32160);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSlicesPerVolume: spv_q  <= cfg_data_i[SliceW-1:0];
        CfgBlockLength:     blen_q <= cfg_data_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  vlnts_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .mode_i              (mode_i),
    .sample_i            (sample_i),
    .slices_per_volume_i (spv_q),
    .block_length_i      (blen_q),
    .req_o               (req),
    .info_o              (info)
  );

  vlnts_tmem u_tmem (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= info.produce;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && info.produce) begin
      s1_beyond_q <= info.beyond;
      s1_bypass_q <= info.bypass;
      s1_sample_q <= sample_i;
    end
  end

  assign tmpl       = s1_bypass_q ? s1_sample_q : rdata;
  assign filtered_d = s1_beyond_q ? '0 : (s1_sample_q - tmpl + MidScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      filtered_q <= filtered_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("Input stalled with no item waiting in the read stage.");

  a_result_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && info.produce |=> s1_valid_q)
    else $error("An accepted sample was lost before the read stage.");

  a_result_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_o)
    else $error("A read-stage item did not reach the output register.");

  a_no_write_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> accept && !mode_i)
    else $error("Template written without an accepted sample.");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the volume-locked noise template subtraction block.
// A directed table and random volume sequences are checked against a local predictor or fixed values.
// Depends on vlnts_pkg and volume_locked_noise_template_subtract.

module tb_top;
  import vlnts_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;
  localparam int PhaseItems  = 245;
  localparam int NumPhases   = 8;
  localparam int MaxReports  = 20;
  localparam int NumRows     = 31;

  typedef enum logic {RowItem, RowCfg} row_kind_e;
  typedef enum logic {ChkModel, ChkFixed} check_e;

  typedef struct packed {
    row_kind_e           kind;
    logic                mode;
    logic [SampleW-1:0]  smp;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    check_e              chk;
    logic [SampleW-1:0]  want;
  } dir_row_t;

  typedef struct packed {
    logic               mode;
    logic [SampleW-1:0] smp;
    check_e             chk;
    logic [SampleW-1:0] want;
  } item_t;

  dir_row_t dir_tab [0:NumRows-1] = '{
    '{RowItem, 1'b0, 16'hABCD, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'h0001, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'hFFFF, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h8000},
    '{RowItem, 1'b0, 16'hFFFF, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h8000},
    '{RowItem, 1'b0, 16'h1234, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h8000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'hFFFF, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h7FFF},
    '{RowItem, 1'b0, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h8001},
    '{RowItem, 1'b0, 16'h1234, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h8000},
    '{RowCfg,  1'b0, 16'h0000, CfgBlockLength,     17'd2, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h8000},
    '{RowItem, 1'b0, 16'hFFFF, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h8000},
    '{RowItem, 1'b0, 16'h5555, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h0000},
    '{RowCfg,  1'b0, 16'h0000, CfgBlockLength,     17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'hFFFF, CfgSlicesPerVolume, 17'd0, ChkFixed, 16'h0000},
    '{RowCfg,  1'b0, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowCfg,  1'b0, 16'h0000, CfgBlockLength,     17'd3, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'h8000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowCfg,  1'b0, 16'h0000, CfgSlicesPerVolume, 17'd2, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'h1111, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'h2222, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b1, 16'h0000, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000},
    '{RowItem, 1'b0, 16'h3333, CfgSlicesPerVolume, 17'd0, ChkModel, 16'h0000}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_mode = 1'b0;
  logic [SampleW-1:0]  in_sample = '0;
  logic                out_stall = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_stall;
  logic                out_valid;
  logic [SampleW-1:0]  filtered;

  // Predictor state.
  bit   [SampleW-1:0]  tmpl_mem [MaxTemplate];
  logic [SliceW-1:0]   spv_m = 8'd1;
  logic [CfgDataW-1:0] blen_m = 17'd32160;
  logic [SliceW-1:0]   slice_pos = '0;
  logic [1:0]          vol_count = '0;
  logic [IdxW-1:0]     cap_ptr = '0;
  logic [IdxW-1:0]     rd_ptr = '0;

  item_t              offer_q [$];
  logic [SampleW-1:0] filtered_due_q [$];
  int                 pending = 0;
  int                 errors = 0;
  int                 n_events = 0;
  int                 n_samples = 0;
  int                 n_results = 0;
  int                 cycles = 0;
  bit                 no_idle = 1'b0;
  bit                 hold_req = 1'b0;
  bit                 hold_done = 1'b0;

  volume_locked_noise_template_subtract dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (in_mode),
    .sample_i    (in_sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .filtered_o  (filtered),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               filtered_due_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit predict_filtered(input logic mode, input logic [SampleW-1:0] smp,
                                          output logic [SampleW-1:0] res);
    int unsigned len;
    len = (blen_m > MaxTemplate) ? MaxTemplate : blen_m;
    res = '0;
    if (mode) begin
      if (slice_pos == 0) begin
        rd_ptr = '0;
        if (vol_count < 2) begin
          vol_count++;
          if (vol_count == 2) cap_ptr = '0;
        end
      end
      if (int'(slice_pos) + 1 >= int'(spv_m)) slice_pos = '0;
      else slice_pos++;
      return 1'b0;
    end
    if (vol_count < 2) return 1'b0;
    if (cap_ptr < len) begin
      tmpl_mem[cap_ptr[AddrW-1:0]] = smp;
      cap_ptr++;
    end
    if (rd_ptr < len) begin
      res = smp - tmpl_mem[rd_ptr[AddrW-1:0]] + MidScale;
      rd_ptr++;
    end
    return 1'b1;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SampleW'($urandom_range(0, 65535));
  endfunction

  task automatic queue_item(input logic mode, input logic [SampleW-1:0] smp,
                            input check_e chk, input logic [SampleW-1:0] want);
    offer_q.push_back('{mode: mode, smp: smp, chk: chk, want: want});
    pending++;
  endtask

  task automatic settle();
    while (pending != 0 || filtered_due_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgSlicesPerVolume) spv_m = val[SliceW-1:0];
    else blen_m = val;
  endtask

  initial begin : source
    item_t              cur;
    logic [SampleW-1:0] res;
    int                 gap_left;
    gap_left = 0;
    cur = '0;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        if (predict_filtered(cur.mode, cur.smp, res))
          filtered_due_q.push_back(cur.chk == ChkFixed ? cur.want : res);
        if (cur.mode) n_events++;
        else n_samples++;
        pending--;
        gap_left = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (in_valid && in_stall) begin
        // The offered item stays put until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (offer_q.size() > 0) begin
        cur = offer_q.pop_front();
        in_mode   <= cur.mode;
        in_sample <= cur.smp;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  initial begin : sink
    int                 hold_left;
    logic [SampleW-1:0] want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n_results++;
        if (filtered_due_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: unexpected item, expected none, got filtered %h", $time, filtered);
        end else begin
          want = filtered_due_q.pop_front();
          if (filtered !== want) begin
            errors++;
            if (errors <= MaxReports)
              $display("%0t: filtered mismatch, expected %h, got %h", $time, want, filtered);
          end
        end
        hold_left = no_idle ? 0 : $urandom_range(0, 13);
        if (hold_req && !hold_done) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  initial begin : main
    int               n;
    int unsigned      r;
    int unsigned      full;
    int unsigned      nsl;
    int unsigned      kmax;
    int unsigned      k;
    logic [SliceW-1:0]   spv_sel;
    logic [CfgDataW-1:0] blen_sel;
    wait (rst_n);
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      if (dir_tab[i].kind == RowCfg) begin
        settle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        queue_item(dir_tab[i].mode, dir_tab[i].smp, dir_tab[i].chk, dir_tab[i].want);
      end
    end
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin spv_sel = 8'd1; blen_sel = 17'd40; end
        1: begin spv_sel = 8'd255; blen_sel = 17'd65536; end
        2: begin spv_sel = 8'd4; blen_sel = 17'd17; end
        3: begin spv_sel = 8'd0; blen_sel = 17'd131071; end
        4: begin spv_sel = 8'd2; blen_sel = 17'd1; end
        5: begin
          spv_sel  = SliceW'($urandom_range(1, 16));
          blen_sel = CfgDataW'($urandom_range(1, 300));
        end
        6: begin spv_sel = 8'd7; blen_sel = 17'd0; end
        default: begin
          spv_sel  = SliceW'($urandom_range(1, 255));
          blen_sel = CfgDataW'($urandom_range(1, 2000));
        end
      endcase
      no_idle  = (ph == 2 || ph == 5);
      hold_req = (ph == 2);
      write_reg(CfgSlicesPerVolume, CfgDataW'(spv_sel));
      write_reg(CfgBlockLength, blen_sel);

      // Mostly whole volumes of slice events with bursts of samples between them.
      full = (spv_m == 0) ? 1 : spv_m;
      kmax = (full > 16) ? 2 : 12;
      n = 0;
      while (n < PhaseItems) begin
        r = $urandom_range(0, 9);
        if (r == 9) begin
          repeat ($urandom_range(1, 12)) begin
            queue_item(1'($urandom_range(0, 1)), pick_sample(), ChkModel, '0);
            n++;
          end
        end else begin
          nsl = (r == 8) ? $urandom_range(0, full) : full;
          for (int s = 0; s < nsl && n < PhaseItems; s++) begin
            queue_item(1'b1, pick_sample(), ChkModel, '0);
            n++;
            k = $urandom_range(0, kmax);
            for (int j = 0; j < k && n < PhaseItems; j++) begin
              queue_item(1'b0, pick_sample(), ChkModel, '0);
              n++;
            end
          end
        end
      end
      settle();
    end

    if (filtered_due_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, filtered_due_q.size());
    end
    $display("Covered %0d slice events and %0d samples, %0d filtered results checked.",
             n_events, n_samples, n_results);
    $display("Swept %0d register settings incl. zero and full-scale values, one long hold.",
             NumPhases + 5);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/vlnts_pkg.sv
rtl/vlnts_ctrl.sv
rtl/vlnts_tmem.sv
rtl/volume_locked_noise_template_subtract.sv
tb/sv/tb_top.sv
